// File: src/telnet_refuser_banner_capture_top_assert.svh
// Assertion macros for the banner capture block.
`ifndef TELNET_REFUSER_BANNER_CAPTURE_TOP_ASSERT_SVH
`define TELNET_REFUSER_BANNER_CAPTURE_TOP_ASSERT_SVH

// Clocked check, disabled while reset is asserted.
`define TRBC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("check failed: %m");

// Same check, also evaluated during reset.
`define TRBC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("check failed: %m");

`endif

// File: src/trbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package trbc_pkg;

  localparam int unsigned BannerCapacity = 2048;
  localparam int unsigned IndexW         = 12;
  localparam int unsigned TickW          = 17;
  localparam int unsigned LimitW         = 16;
  localparam int unsigned CfgIndexW      = 2;

  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

  localparam logic [7:0] CodeIac  = 8'd255;
  localparam logic [7:0] CodeDont = 8'd254;
  localparam logic [7:0] CodeDo   = 8'd253;
  localparam logic [7:0] CodeWont = 8'd252;
  localparam logic [7:0] CodeWill = 8'd251;

  localparam logic [CfgIndexW-1:0] CfgConnectLimit = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgIdleLimit    = 2'd1;

  typedef enum logic [1:0] {
    ModeOpen = 2'd0,
    ModeByte = 2'd1,
    ModeTick = 2'd2,
    ModePeer = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KindBanner = 2'd0,
    KindReply  = 2'd1,
    KindClose  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ReasonPeer    = 2'd0,
    ReasonFull    = 2'd1,
    ReasonConnect = 2'd2,
    ReasonIdle    = 2'd3
  } reason_e;

  typedef enum logic [2:0] {
    PhText = 3'b001,
    PhIac  = 3'b010,
    PhCmd  = 3'b100
  } phase_e;

  // Results raised by one input transaction; reply triples differ only in the byte.
  typedef struct packed {
    logic [1:0]        cnt;
    kind_e             kind;
    logic [2:0][7:0]   bytes;
    logic [IndexW-1:0] index;
    logic              flag;
    reason_e           reason;
  } bundle_t;

endpackage

`default_nettype wire

// File: src/trbc_session.sv
`timescale 1ns / 1ps
`default_nettype none

module trbc_session (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             accept_i,
  input  wire logic [1:0]                       mode_i,
  input  wire logic [7:0]                       rx_byte_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [trbc_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  wire logic [trbc_pkg::LimitW-1:0]      cfg_data_i,
  output trbc_pkg::bundle_t                     bundle_o
);
  import trbc_pkg::*;

  logic [LimitW-1:0] connect_limit_q, idle_limit_q;

  logic              open_q, open_d;
  phase_e            phase_q, phase_d;
  logic [7:0]        pend_q, pend_d;
  logic [IndexW-1:0] count_q, count_d;
  logic              flag_q, flag_d;
  logic [TickW-1:0]  open_ticks_q, open_ticks_d;
  logic [TickW-1:0]  quiet_ticks_q, quiet_ticks_d;

  logic [TickW-1:0]  ot_inc, qt_inc;
  logic              close;
  reason_e           reason;
  logic [7:0]        answer;
  logic              refuse;
  mode_e             mode;

  assign mode   = mode_e'(mode_i);
  assign ot_inc = (open_ticks_q  == TickMax) ? open_ticks_q  : open_ticks_q  + 1'b1;
  assign qt_inc = (quiet_ticks_q == TickMax) ? quiet_ticks_q : quiet_ticks_q + 1'b1;

  always_comb begin
    open_d        = open_q;
    phase_d       = phase_q;
    pend_d        = pend_q;
    count_d       = count_q;
    flag_d        = flag_q;
    open_ticks_d  = open_ticks_q;
    quiet_ticks_d = quiet_ticks_q;
    close         = 1'b0;
    reason        = ReasonPeer;
    answer        = CodeWont;
    refuse        = 1'b0;

    bundle_o        = '0;
    bundle_o.kind   = KindBanner;
    bundle_o.reason = ReasonPeer;
    bundle_o.flag   = flag_q;

    case (mode)
      ModeOpen: begin
        open_d        = 1'b1;
        phase_d       = PhText;
        pend_d        = '0;
        count_d       = '0;
        flag_d        = 1'b0;
        open_ticks_d  = '0;
        quiet_ticks_d = '0;
      end
      ModePeer: begin
        if (open_q) begin
          close  = 1'b1;
          reason = ReasonPeer;
        end
      end
      ModeTick: begin
        if (open_q) begin
          open_ticks_d  = ot_inc;
          quiet_ticks_d = qt_inc;
          if (ot_inc > TickW'(connect_limit_q)) begin
            close  = 1'b1;
            reason = ReasonConnect;
          end else if (count_q != '0 && qt_inc > TickW'(idle_limit_q)) begin
            close  = 1'b1;
            reason = ReasonIdle;
          end
        end
      end
      ModeByte: begin
        if (open_q) begin
          case (phase_q)
            PhIac: begin
              quiet_ticks_d = '0;
              pend_d        = rx_byte_i;
              phase_d       = PhCmd;
            end
            PhCmd: begin
              quiet_ticks_d = '0;
              pend_d        = '0;
              phase_d       = PhText;
              if (pend_q == CodeWill || pend_q == CodeWont) begin
                refuse = 1'b1;
                answer = CodeDont;
              end else if (pend_q == CodeDo || pend_q == CodeDont) begin
                refuse = 1'b1;
                answer = CodeWont;
              end
              if (refuse) begin
                flag_d          = 1'b1;
                bundle_o.cnt    = 2'd3;
                bundle_o.kind   = KindReply;
                bundle_o.bytes  = {rx_byte_i, answer, CodeIac};
                bundle_o.flag   = 1'b1;
              end
            end
            default: begin
              if ({1'b0, count_q} >= (IndexW+1)'(BannerCapacity)) begin
                close  = 1'b1;
                reason = ReasonFull;
              end else begin
                quiet_ticks_d = '0;
                if (rx_byte_i == CodeIac) begin
                  phase_d = PhIac;
                end else begin
                  bundle_o.cnt      = 2'd1;
                  bundle_o.bytes[0] = rx_byte_i;
                  bundle_o.index    = count_q;
                  count_d           = count_q + 1'b1;
                end
              end
            end
          endcase
        end
      end
      default: ;
    endcase

    if (close) begin
      bundle_o.cnt    = 2'd1;
      bundle_o.kind   = KindClose;
      bundle_o.bytes  = '0;
      bundle_o.index  = count_q;
      bundle_o.flag   = flag_q;
      bundle_o.reason = reason;
      open_d        = 1'b0;
      phase_d       = PhText;
      pend_d        = '0;
      count_d       = '0;
      flag_d        = 1'b0;
      open_ticks_d  = '0;
      quiet_ticks_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      connect_limit_q <= LimitW'(10);
      idle_limit_q    <= LimitW'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgConnectLimit) connect_limit_q <= cfg_data_i;
      if (cfg_index_i == CfgIdleLimit)    idle_limit_q    <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q        <= 1'b0;
      phase_q       <= PhText;
      pend_q        <= '0;
      count_q       <= '0;
      flag_q        <= 1'b0;
      open_ticks_q  <= '0;
      quiet_ticks_q <= '0;
    end else if (accept_i) begin
      open_q        <= open_d;
      phase_q       <= phase_d;
      pend_q        <= pend_d;
      count_q       <= count_d;
      flag_q        <= flag_d;
      open_ticks_q  <= open_ticks_d;
      quiet_ticks_q <= quiet_ticks_d;
    end
  end

endmodule

`default_nettype wire

// File: src/trbc_out_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module trbc_out_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  trbc_pkg::bundle_t                  bundle_i,
  output logic                               room_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         kind_o,
  output logic [7:0]                         out_byte_o,
  output logic [trbc_pkg::IndexW-1:0]        byte_index_o,
  output logic                               telnet_seen_o,
  output logic [1:0]                         close_reason_o,
  output logic                               last_o
);
  import trbc_pkg::*;

  bundle_t    bundle_q;
  logic [1:0] left_q, left_d;
  logic [1:0] ptr_q, ptr_d;
  logic       take;

  assign out_valid_o = (left_q != 2'd0);
  assign take        = out_valid_o && out_ready_i;
  // Room for a new transaction once the final pending result leaves this cycle.
  assign room_o      = (left_q == 2'd0) || (left_q == 2'd1 && out_ready_i);

  always_comb begin
    left_d = left_q;
    ptr_d  = ptr_q;
    if (take) begin
      left_d = left_q - 2'd1;
      ptr_d  = ptr_q + 2'd1;
    end
    if (load_i) begin
      left_d = bundle_i.cnt;
      ptr_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 2'd0;
      ptr_q  <= 2'd0;
    end else begin
      left_q <= left_d;
      ptr_q  <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) bundle_q <= bundle_i;
  end

  always_comb begin
    case (ptr_q)
      2'd1:    out_byte_o = bundle_q.bytes[1];
      2'd2:    out_byte_o = bundle_q.bytes[2];
      default: out_byte_o = bundle_q.bytes[0];
    endcase
  end

  assign kind_o         = bundle_q.kind;
  assign byte_index_o   = bundle_q.index;
  assign telnet_seen_o  = bundle_q.flag;
  assign close_reason_o = bundle_q.reason;
  assign last_o         = (left_q == 2'd1);

endmodule

`default_nettype wire

// File: src/telnet_refuser_banner_capture_top.sv
// Banner capture with telnet option refusal, one connection.
// Input channel (in_valid_i/in_ready_o) carries events: mode_i selects open,
// received byte (rx_byte_i), tick or peer end. Output channel
// (out_valid_o/out_ready_i) carries results: stored banner bytes, reply bytes
// for the peer and close reports. last_o marks the final result of an event.
// Results of an event are registered and appear in the cycle after its transaction.
// Throughput: one event per cycle while each yields at most one result and
// the receiver keeps out_ready_i high; a refused option yields three reply
// bytes and holds the input until the last of them leaves. Events that
// yield no result are still taken one per cycle.
// The result register decouples the sides: a new event is taken in the cycle
// its predecessor's final result leaves. When the receiver stalls, the
// pending result holds and the input stalls behind it.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) land at once;
// index 0 is the connect limit, 1 the idle limit, others are ignored.
// Reset: no session open, limits 10 and 1, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module telnet_refuser_banner_capture_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [trbc_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  wire logic [trbc_pkg::LimitW-1:0]      cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       mode_i,
  input  wire logic [7:0]                       rx_byte_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [1:0]                            kind_o,
  output logic [7:0]                            out_byte_o,
  output logic [trbc_pkg::IndexW-1:0]           byte_index_o,
  output logic                                  telnet_seen_o,
  output logic [1:0]                            close_reason_o,
  output logic                                  last_o
);
  import trbc_pkg::*;

  `include "telnet_refuser_banner_capture_top_assert.svh"

  bundle_t bundle;
  logic    accept;

  assign accept = in_valid_i && in_ready_o;

  trbc_session u_session (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .bundle_o    (bundle)
  );

  trbc_out_seq u_out_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept),
    .bundle_i       (bundle),
    .room_o         (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .out_byte_o     (out_byte_o),
    .byte_index_o   (byte_index_o),
    .telnet_seen_o  (telnet_seen_o),
    .close_reason_o (close_reason_o),
    .last_o         (last_o)
  );

  `TRBC_ASSERT_ALWAYS(a_ready_when_empty, clk_i, !out_valid_o |-> in_ready_o)
  `TRBC_ASSERT(a_reply_sets_flag, clk_i, rst_ni,
    (out_valid_o && kind_o == KindReply) |-> telnet_seen_o)
  `TRBC_ASSERT(a_close_byte_zero, clk_i, rst_ni,
    (out_valid_o && kind_o == KindClose) |-> (out_byte_o == 8'd0))
  `TRBC_ASSERT(a_banner_no_reason, clk_i, rst_ni,
    (out_valid_o && kind_o == KindBanner) |-> (close_reason_o == ReasonPeer && last_o))

endmodule

`default_nettype wire

// File: tb/sv/tb_telnet_refuser_banner_capture_top.sv
`timescale 1ns / 1ps

module tb_telnet_refuser_banner_capture_top;
  import trbc_pkg::*;

  // Longest quiet stretch of a correct run comes from receiver hold-off,
  // sender gaps and settle pauses; allow a wide margin.
  localparam int unsigned StallLimit   = 5000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldOffLen   = 80;

  localparam logic [CfgIndexW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIndexW-1:0] CfgSpareB = 2'd3;
  localparam logic [LimitW-1:0]    LimitMax  = {LimitW{1'b1}};
  localparam logic [LimitW-1:0]    LimitZero = '0;

  typedef struct {
    kind_e             kind;
    logic [7:0]        data;
    logic [IndexW-1:0] index;
    logic              flag;
    reason_e           reason;
    logic              last;
  } capture_result_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [LimitW-1:0]    cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic [1:0]           mode_i      = '0;
  logic [7:0]           rx_byte_i   = '0;
  logic                 out_ready_i = 1'b0;

  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [1:0]           kind_o;
  logic [7:0]           out_byte_o;
  logic [IndexW-1:0]    byte_index_o;
  logic                 telnet_seen_o;
  logic [1:0]           close_reason_o;
  logic                 last_o;

  telnet_refuser_banner_capture_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .out_byte_o     (out_byte_o),
    .byte_index_o   (byte_index_o),
    .telnet_seen_o  (telnet_seen_o),
    .close_reason_o (close_reason_o),
    .last_o         (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Session tracker state and limits
  logic              sess_open;
  phase_e            parse_ph;
  logic [7:0]        held_cmd;
  logic [IndexW-1:0] banner_len;
  logic              refused;
  logic [TickW-1:0]  open_age;
  logic [TickW-1:0]  quiet_age;
  logic [LimitW-1:0] connect_lim = 16'd10;
  logic [LimitW-1:0] idle_lim    = 16'd1;

  capture_result_t capture_results_q[$];
  int unsigned     session_events = 0;
  int unsigned     mismatch_count = 0;
  int unsigned     send_idle_pct  = 0;
  int unsigned     stall_pct      = 0;
  int unsigned     hold_req       = 0;
  int unsigned     hold_left      = 0;
  int unsigned     quiet_cycles   = 0;

  function automatic void clear_session_state();
    sess_open  = 1'b0;
    parse_ph   = PhText;
    held_cmd   = '0;
    banner_len = '0;
    refused    = 1'b0;
    open_age   = '0;
    quiet_age  = '0;
  endfunction

  function automatic void push_result(kind_e k, logic [7:0] d, logic [IndexW-1:0] idx,
                                      reason_e r, logic l);
    capture_result_t res;
    res.kind   = k;
    res.data   = d;
    res.index  = idx;
    res.flag   = refused;
    res.reason = r;
    res.last   = l;
    capture_results_q.push_back(res);
  endfunction

  function automatic void close_session(reason_e r);
    push_result(KindClose, 8'h00, banner_len, r, 1'b1);
    clear_session_state();
  endfunction

  function automatic void predict_capture(mode_e m, logic [7:0] b);
    logic [7:0] answer;
    answer = 8'h00;
    if (m == ModeOpen) begin
      clear_session_state();
      sess_open = 1'b1;
      session_events++;
      return;
    end
    if (!sess_open) return;
    session_events++;
    if (m == ModePeer) begin
      close_session(ReasonPeer);
    end else if (m == ModeTick) begin
      if (open_age != TickMax) open_age++;
      if (quiet_age != TickMax) quiet_age++;
      // connect limit wins when both run out on the same tick
      if (open_age > connect_lim) close_session(ReasonConnect);
      else if (banner_len != 0 && quiet_age > idle_lim) close_session(ReasonIdle);
    end else if (parse_ph == PhText) begin
      if (banner_len >= BannerCapacity) begin
        close_session(ReasonFull);
      end else begin
        quiet_age = '0;
        if (b == CodeIac) begin
          parse_ph = PhIac;
        end else begin
          push_result(KindBanner, b, banner_len, ReasonPeer, 1'b1);
          banner_len++;
        end
      end
    end else if (parse_ph == PhIac) begin
      quiet_age = '0;
      held_cmd  = b;
      parse_ph  = PhCmd;
    end else begin
      quiet_age = '0;
      parse_ph  = PhText;
      if (held_cmd == CodeWill || held_cmd == CodeWont) answer = CodeDont;
      else if (held_cmd == CodeDo || held_cmd == CodeDont) answer = CodeWont;
      held_cmd = '0;
      if (answer != 8'h00) begin
        refused = 1'b1;
        push_result(KindReply, CodeIac, '0, ReasonPeer, 1'b0);
        push_result(KindReply, answer, '0, ReasonPeer, 1'b0);
        push_result(KindReply, b, '0, ReasonPeer, 1'b1);
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Must be called in step with the clock; returns once the design has accepted the event.
  task automatic send_event(input mode_e m, input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_capture(m, b);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (capture_results_q.size() != 0) @(posedge clk_i);
    // events without results may still be in flight
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIndexW-1:0] idx, input logic [LimitW-1:0] val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgConnectLimit) connect_lim = val;
    else if (idx == CfgIdleLimit) idle_lim = val;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    wait_idle();
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  task automatic send_triple(input logic [7:0] cmd, input logic [7:0] opt);
    send_event(ModeByte, CodeIac);
    send_event(ModeByte, cmd);
    send_event(ModeByte, opt);
  endtask

  task automatic test_ignored_when_closed();
    send_event(ModeByte, 8'hAA);
    send_event(ModeTick, 8'h55);
    send_event(ModePeer, 8'hFF);
  endtask

  task automatic test_option_refusal();
    send_event(ModeOpen, 8'h00);
    send_event(ModeByte, 8'h00);
    send_triple(CodeWill, 8'h00);
    send_triple(CodeDo, 8'hFF);
    send_triple(CodeWont, 8'h55);
    send_triple(CodeDont, 8'hAA);
    send_triple(8'hF0, 8'h01);
    send_triple(CodeIac, 8'h07);
    send_event(ModeByte, 8'hFE);
    // restart clears count and flag without a close report
    send_event(ModeOpen, 8'h33);
    send_event(ModeByte, 8'h7F);
    send_event(ModePeer, 8'h00);
  endtask

  task automatic test_idle_timeout();
    send_event(ModeOpen, 8'h00);
    send_event(ModeTick, 8'h00);
    send_event(ModeTick, 8'h00);
    send_event(ModeByte, 8'h41);
    send_event(ModeTick, 8'h00);
    send_event(ModeTick, 8'h00);
  endtask

  task automatic test_connect_timeout();
    send_event(ModeOpen, 8'h00);
    repeat (11) send_event(ModeTick, 8'h00);
  endtask

  task automatic test_zero_and_spare_limits();
    write_cfg(CfgSpareA, 16'($urandom_range(65535)));
    write_cfg(CfgSpareB, 16'($urandom_range(65535)));
    write_cfg(CfgConnectLimit, LimitZero);
    send_event(ModeOpen, 8'h00);
    send_event(ModeTick, 8'h00);
    write_cfg(CfgConnectLimit, 16'd100);
    write_cfg(CfgIdleLimit, LimitZero);
    send_event(ModeOpen, 8'h00);
    send_event(ModeTick, 8'h00);
    send_event(ModeByte, 8'h80);
    send_event(ModeTick, 8'h00);
  endtask

  task automatic test_simultaneous_timeouts();
    write_cfg(CfgConnectLimit, 16'd3);
    write_cfg(CfgIdleLimit, 16'd3);
    send_event(ModeOpen, 8'h00);
    send_event(ModeByte, 8'h01);
    repeat (4) send_event(ModeTick, 8'h00);
  endtask

  task automatic test_longest_limits();
    write_cfg(CfgConnectLimit, LimitMax);
    write_cfg(CfgIdleLimit, LimitMax);
    send_event(ModeOpen, 8'h00);
    send_event(ModeByte, 8'h5A);
    repeat (16) send_event(ModeTick, 8'h00);
    send_event(ModePeer, 8'h00);
  endtask

  task automatic test_buffer_full_with_backpressure();
    // hold the receiver off so the result register fills and input stalls
    hold_req = HoldOffLen;
    send_event(ModeOpen, 8'h00);
    repeat (BannerCapacity) send_event(ModeByte, 8'($urandom_range(254)));
    send_event(ModeByte, CodeIac);
  endtask

  task automatic test_random_traffic(input int unsigned events, input int unsigned send_pct,
                                     input int unsigned recv_pct, input logic [LimitW-1:0] conn,
                                     input logic [LimitW-1:0] idle);
    int unsigned goal;
    int unsigned pick;
    set_idling(send_pct, recv_pct);
    write_cfg(CfgConnectLimit, conn);
    write_cfg(CfgIdleLimit, idle);
    write_cfg(CfgSpareA, 16'($urandom_range(65535)));
    goal = session_events + events;
    while (session_events < goal) begin
      pick = $urandom_range(99);
      if (!sess_open) begin
        if (pick < 85) send_event(ModeOpen, 8'($urandom_range(255)));
        else send_event(mode_e'($urandom_range(3)), 8'($urandom_range(255)));
      end else if (pick < 50) begin
        send_event(ModeByte, 8'($urandom_range(255)));
      end else if (pick < 68) begin
        send_triple(($urandom_range(99) < 80) ? 8'($urandom_range(254, 251))
                                              : 8'($urandom_range(255)),
                    8'($urandom_range(255)));
      end else if (pick < 72) begin
        // broken triple: IAC then one event of random mode, which may cut it short
        send_event(ModeByte, CodeIac);
        send_event(mode_e'($urandom_range(3)), 8'($urandom_range(255)));
      end else if (pick < 92) begin
        repeat ($urandom_range(3, 1)) send_event(ModeTick, 8'($urandom_range(255)));
      end else if (pick < 96) begin
        send_event(ModePeer, 8'($urandom_range(255)));
      end else begin
        send_event(ModeOpen, 8'($urandom_range(255)));
      end
    end
  endtask

  // Receiver: random stalls, plus a counted hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    capture_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (capture_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d byte=%02h index=%0d",
                                  kind_o, out_byte_o, byte_index_o));
      end else begin
        want = capture_results_q.pop_front();
        if (kind_o !== want.kind || out_byte_o !== want.data ||
            byte_index_o !== want.index || telnet_seen_o !== want.flag ||
            close_reason_o !== want.reason || last_o !== want.last)
          report_mismatch($sformatf(
            {"got kind=%0d byte=%02h index=%0d seen=%0b reason=%0d last=%0b, ",
             "want %0d %02h %0d %0b %0d %0b"},
            kind_o, out_byte_o, byte_index_o, telnet_seen_o, close_reason_o, last_o,
            want.kind, want.data, want.index, want.flag, want.reason, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("telnet_refuser_banner_capture_top regression: fail");
      $finish;
    end
  end

  initial begin
    clear_session_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ignored_when_closed();
    test_option_refusal();
    test_idle_timeout();
    test_connect_timeout();
    test_zero_and_spare_limits();
    test_simultaneous_timeouts();
    set_idling(0, 0);
    test_longest_limits();
    test_buffer_full_with_backpressure();

    test_random_traffic(118, 0, 0, 16'($urandom_range(40, 8)), 16'($urandom_range(6, 1)));
    test_random_traffic(118, 84, 0, 16'($urandom_range(20, 2)), LimitMax);
    test_random_traffic(118, 0, 84, LimitMax, 16'($urandom_range(4, 1)));
    test_random_traffic(118, 28, 28, 16'd1, 16'd1);

    wait_idle();
    if (capture_results_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", capture_results_q.size()));
    if (mismatch_count == 0)
      $display("telnet_refuser_banner_capture_top regression: pass");
    else
      $display("telnet_refuser_banner_capture_top regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/trbc_pkg.sv
src/trbc_session.sv
src/trbc_out_seq.sv
src/telnet_refuser_banner_capture_top.sv
tb/sv/tb_telnet_refuser_banner_capture_top.sv
